// File: hdl/dpeu_pkg.sv
package dpeu_pkg;

  // Field widths of the instruction and the register file
  localparam int unsigned WordW  = 32;
  localparam int unsigned RegCnt = 16;
  localparam int unsigned RegIdxW = 4;

  // Packed result: executed, result_value, dest_index, dest_written, flags_nzc, bad_opcode
  localparam int unsigned OutFieldsW = 1 + WordW + RegIdxW + 1 + 3 + 1;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Data-processing opcodes
  localparam logic [3:0] OpAnd = 4'd0;
  localparam logic [3:0] OpEor = 4'd1;
  localparam logic [3:0] OpSub = 4'd2;
  localparam logic [3:0] OpRsb = 4'd3;
  localparam logic [3:0] OpAdd = 4'd4;
  localparam logic [3:0] OpTst = 4'd8;
  localparam logic [3:0] OpTeq = 4'd9;
  localparam logic [3:0] OpCmp = 4'd10;
  localparam logic [3:0] OpOrr = 4'd12;
  localparam logic [3:0] OpMov = 4'd13;

  // Condition codes
  localparam logic [3:0] CondEq = 4'd0;
  localparam logic [3:0] CondNe = 4'd1;
  localparam logic [3:0] CondCs = 4'd2;
  localparam logic [3:0] CondCc = 4'd3;
  localparam logic [3:0] CondMi = 4'd4;
  localparam logic [3:0] CondPl = 4'd5;
  localparam logic [3:0] CondVs = 4'd6;
  localparam logic [3:0] CondVc = 4'd7;
  localparam logic [3:0] CondHi = 4'd8;
  localparam logic [3:0] CondLs = 4'd9;
  localparam logic [3:0] CondGe = 4'd10;
  localparam logic [3:0] CondLt = 4'd11;
  localparam logic [3:0] CondGt = 4'd12;
  localparam logic [3:0] CondLe = 4'd13;
  localparam logic [3:0] CondAl = 4'd14;
  localparam logic [3:0] CondNv = 4'd15;

  // Shift types
  localparam logic [1:0] ShLsl = 2'd0;
  localparam logic [1:0] ShLsr = 2'd1;
  localparam logic [1:0] ShAsr = 2'd2;
  localparam logic [1:0] ShRor = 2'd3;

  // Flags, bit 2 N, bit 1 Z, bit 0 C
  typedef struct packed {
    logic n;
    logic z;
    logic c;
  } flags_t;

  // Operand 2 with shifter carry-out
  typedef struct packed {
    logic [WordW-1:0] value;
    logic             carry;
  } op2_t;

  // Outcome of one instruction
  typedef struct packed {
    logic             executed;
    logic [WordW-1:0] result;
    logic             dest_written;
    logic             flags_we;
    flags_t           flags;
    logic             bad_opcode;
  } alu_res_t;

endpackage

// File: hdl/dpeu_ram.sv
module dpeu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads; a same-cycle write to the address passes through
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
      rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end
  end

endmodule

// File: hdl/dpeu_regfile.sv
module dpeu_regfile
  import dpeu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [RegIdxW-1:0] waddr,
  input  logic [WordW-1:0]   wdata,
  input  logic               re,
  input  logic [RegIdxW-1:0] raddr_n,
  input  logic [RegIdxW-1:0] raddr_m,
  input  logic [RegIdxW-1:0] raddr_s,
  output logic [WordW-1:0]   rdata_n,
  output logic [WordW-1:0]   rdata_m,
  output logic [WordW-1:0]   rdata_s
);

  logic [RegCnt-1:0] written;
  logic              valid_n;
  logic              valid_m;
  logic              valid_s;
  logic [WordW-1:0]  ram_n;
  logic [WordW-1:0]  ram_m;
  logic [WordW-1:0]  ram_s;
  logic [WordW-1:0]  ram_spare;

  // Two copies give three read ports
  dpeu_ram #(.WIDTH(WordW), .DEPTH(RegCnt)) u_ram_nm (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_n),
    .raddr_b (raddr_m),
    .rdata_a (ram_n),
    .rdata_b (ram_m)
  );

  dpeu_ram #(.WIDTH(WordW), .DEPTH(RegCnt)) u_ram_s (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_s),
    .raddr_b (raddr_s),
    .rdata_a (ram_s),
    .rdata_b (ram_spare)
  );

  // Track which registers hold data since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // Sample valid bits alongside the RAM reads
  always_ff @(posedge clk) begin
    if (re) begin
      valid_n <= written[raddr_n] || (we && (waddr == raddr_n));
      valid_m <= written[raddr_m] || (we && (waddr == raddr_m));
      valid_s <= written[raddr_s] || (we && (waddr == raddr_s));
    end
  end

  // Unwritten registers read as zero
  assign rdata_n = valid_n ? ram_n : '0;
  assign rdata_m = valid_m ? ram_m : '0;
  assign rdata_s = valid_s ? (ram_s & ram_spare) : '0;

endmodule

// File: hdl/dpeu_shifter.sv
module dpeu_shifter
  import dpeu_pkg::*;
(
  input  logic [WordW-1:0] instr,
  input  logic [WordW-1:0] rm_val,
  input  logic [WordW-1:0] rs_val,
  input  logic             cin,
  output op2_t             op2
);

  logic [4:0]             rot;
  logic [2*WordW-1:0]     imm_pair;
  logic [7:0]             amt;
  logic [4:0]             amt5;
  logic                   amt_big;
  logic                   amt_eq32;
  logic [WordW:0]         lsl_ext;
  logic [WordW:0]         lsr_ext;
  logic signed [WordW:0]  asr_ext;
  logic [2*WordW-1:0]     ror_pair;

  always_comb begin
    // Immediate form: rotate imm8 right by twice the rotate field
    rot      = {instr[11:8], 1'b0};
    imm_pair = {24'b0, instr[7:0], 24'b0, instr[7:0]} >> rot;

    // Register form: amount from Rs low byte or from the instruction
    amt      = instr[4] ? rs_val[7:0] : {3'b0, instr[11:7]};
    amt5     = amt[4:0];
    amt_big  = |amt[7:5];
    amt_eq32 = (amt == 8'd32);
    lsl_ext  = {1'b0, rm_val} << amt5;
    lsr_ext  = {rm_val, 1'b0} >> amt5;
    asr_ext  = $signed({rm_val, 1'b0}) >>> amt5;
    ror_pair = {rm_val, rm_val} >> amt5;

    if (instr[25]) begin
      op2.value = imm_pair[WordW-1:0];
      op2.carry = (rot == 5'd0) ? cin : imm_pair[WordW-1];
    end else if (amt == 8'd0) begin
      op2.value = rm_val;
      op2.carry = cin;
    end else begin
      case (instr[6:5])
        ShLsl: begin
          if (amt_big) begin
            op2.value = '0;
            op2.carry = amt_eq32 ? rm_val[0] : 1'b0;
          end else begin
            op2.value = lsl_ext[WordW-1:0];
            op2.carry = lsl_ext[WordW];
          end
        end
        ShLsr: begin
          if (amt_big) begin
            op2.value = '0;
            op2.carry = amt_eq32 ? rm_val[WordW-1] : 1'b0;
          end else begin
            op2.value = lsr_ext[WordW:1];
            op2.carry = lsr_ext[0];
          end
        end
        ShAsr: begin
          if (amt_big) begin
            op2.value = {WordW{rm_val[WordW-1]}};
            op2.carry = rm_val[WordW-1];
          end else begin
            op2.value = asr_ext[WordW:1];
            op2.carry = asr_ext[0];
          end
        end
        default: begin
          op2.value = ror_pair[WordW-1:0];
          op2.carry = ror_pair[WordW-1];
        end
      endcase
    end
  end

endmodule

// File: hdl/dpeu_alu.sv
module dpeu_alu
  import dpeu_pkg::*;
(
  input  logic [WordW-1:0] instr,
  input  logic [WordW-1:0] rn_val,
  input  op2_t             op2,
  input  flags_t           flags,
  output alu_res_t         res
);

  logic             cond_ok;
  logic             op_ok;
  logic             logical;
  logic             writes;
  logic [WordW-1:0] logic_res;
  logic [WordW-1:0] add_x;
  logic [WordW-1:0] add_y;
  logic             add_ci;
  logic [WordW:0]   sum;
  logic [WordW-1:0] value;

  // Condition check against the current flags; V reads as zero
  always_comb begin
    unique case (instr[31:28])
      CondEq:  cond_ok = flags.z;
      CondNe:  cond_ok = !flags.z;
      CondCs:  cond_ok = flags.c;
      CondCc:  cond_ok = !flags.c;
      CondMi:  cond_ok = flags.n;
      CondPl:  cond_ok = !flags.n;
      CondVs:  cond_ok = 1'b0;
      CondVc:  cond_ok = 1'b1;
      CondHi:  cond_ok = flags.c && !flags.z;
      CondLs:  cond_ok = !flags.c || flags.z;
      CondGe:  cond_ok = !flags.n;
      CondLt:  cond_ok = flags.n;
      CondGt:  cond_ok = !flags.z && !flags.n;
      CondLe:  cond_ok = flags.z || flags.n;
      CondAl:  cond_ok = 1'b1;
      CondNv:  cond_ok = 1'b0;
      default: cond_ok = 1'b0;
    endcase
  end

  // Opcode decode and operand selection for the shared adder
  always_comb begin
    op_ok     = 1'b1;
    logical   = 1'b1;
    writes    = 1'b1;
    logic_res = '0;
    add_x     = rn_val;
    add_y     = ~op2.value;
    add_ci    = 1'b1;
    case (instr[24:21])
      OpAnd, OpTst: logic_res = rn_val & op2.value;
      OpEor, OpTeq: logic_res = rn_val ^ op2.value;
      OpOrr:        logic_res = rn_val | op2.value;
      OpMov:        logic_res = op2.value;
      OpSub, OpCmp: logical   = 1'b0;
      OpRsb: begin
        logical = 1'b0;
        add_x   = op2.value;
        add_y   = ~rn_val;
      end
      OpAdd: begin
        logical = 1'b0;
        add_y   = op2.value;
        add_ci  = 1'b0;
      end
      default: op_ok = 1'b0;
    endcase
    if ((instr[24:21] == OpTst) || (instr[24:21] == OpTeq) || (instr[24:21] == OpCmp)) begin
      writes = 1'b0;
    end
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{WordW{1'b0}}, add_ci};
  assign value = logical ? logic_res : sum[WordW-1:0];

  // Assemble the outcome; a failed condition or bad opcode changes nothing
  always_comb begin
    res.executed     = cond_ok && op_ok;
    res.result       = res.executed ? value : '0;
    res.dest_written = res.executed && writes;
    res.flags_we     = res.executed && instr[20];
    res.bad_opcode   = cond_ok && !op_ok;
    if (res.flags_we) begin
      res.flags.n = value[WordW-1];
      res.flags.z = (value == '0);
      res.flags.c = logical ? op2.carry : sum[WordW];
    end else begin
      res.flags = flags;
    end
  end

endmodule

// File: hdl/data_processing_execute_unit.sv
// Channel  Dir  Width  Contents (lowest bit first)
// s_*      in   32     instr_word
// m_*      out  48     executed, result_value, dest_index, dest_written,
//                      flags_nzc, bad_opcode, zero fill
//
// One instruction per clock while the output is not stalled: accepted into the
// instruction register, then executed (register read, shifter, adder) into the
// result register. A presented result can make its output transfer at the next
// edge at the earliest.
// Register file reads are issued at the input transfer; a result written in
// the same cycle is passed straight through to the next instruction.
// Reset clears the flags, the register-valid bits and both stage valids.
// A stalled output holds the result; the instruction register then holds too.
module data_processing_execute_unit
  import dpeu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [WordW-1:0]    s_tdata,   // instr_word
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata    // executed, result_value, dest_index,
                                         // dest_written, flags_nzc, bad_opcode
);

  logic             accept;
  logic             fire;
  logic             ins_valid;
  logic [WordW-1:0] instr;
  flags_t           flags;
  logic [WordW-1:0] rn_val;
  logic [WordW-1:0] rm_val;
  logic [WordW-1:0] rs_val;
  op2_t             op2;
  alu_res_t         res;

  // Handshake: execute when the result register is free or draining
  assign fire     = ins_valid && (!m_tvalid || m_tready);
  assign s_tready = !ins_valid || fire;
  assign accept   = s_tvalid && s_tready;

  // Instruction register
  always_ff @(posedge clk) begin
    if (rst) begin
      ins_valid <= 1'b0;
    end else if (accept) begin
      ins_valid <= 1'b1;
    end else if (fire) begin
      ins_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      instr <= s_tdata;
    end
  end

  dpeu_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (fire && res.dest_written),
    .waddr   (instr[15:12]),
    .wdata   (res.result),
    .re      (accept),
    .raddr_n (s_tdata[19:16]),
    .raddr_m (s_tdata[3:0]),
    .raddr_s (s_tdata[11:8]),
    .rdata_n (rn_val),
    .rdata_m (rm_val),
    .rdata_s (rs_val)
  );

  dpeu_shifter u_shifter (
    .instr  (instr),
    .rm_val (rm_val),
    .rs_val (rs_val),
    .cin    (flags.c),
    .op2    (op2)
  );

  dpeu_alu u_alu (
    .instr  (instr),
    .rn_val (rn_val),
    .op2    (op2),
    .flags  (flags),
    .res    (res)
  );

  // Status flags
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (fire && res.flags_we) begin
      flags <= res.flags;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {{(OutDataW - OutFieldsW){1'b0}}, res.bad_opcode, res.flags,
                  res.dest_written, instr[15:12], res.result, res.executed};
    end
  end

  // An instruction never reports both executed and a bad opcode
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[41]))
    else $error("executed and bad_opcode both set");

  // A register write only happens for an executed instruction
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[37] |-> m_tdata[0])
    else $error("dest_written without executed");

  // A waiting instruction is not dropped
  assert property (@(posedge clk) disable iff (rst)
    ins_valid && !fire |=> ins_valid && $stable(instr))
    else $error("instruction register lost an instruction");

  // Flags move only when an instruction executes
  assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(flags))
    else $error("flags changed without an executed instruction");

  // Reported flags match the live flags right after execution
  assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tdata[40:38] == flags)
    else $error("reported flags differ from status flags");

endmodule

// File: dv/dpeu_checker.sv
module dpeu_checker
  import dpeu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [WordW-1:0]    s_tdata,     // instr_word
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutDataW-1:0] m_tdata,     // executed, result_value, dest_index,
                                           // dest_written, flags_nzc, bad_opcode
  output int unsigned         errors,
  output int unsigned         pending,
  output int unsigned         n_executed,
  output int unsigned         n_bad
);

  // Bit positions of the result fields in m_tdata
  localparam int unsigned ExecBit  = 0;
  localparam int unsigned ValueLo  = 1;
  localparam int unsigned RdLo     = ValueLo + WordW;
  localparam int unsigned WroteBit = RdLo + RegIdxW;
  localparam int unsigned FlagsLo  = WroteBit + 1;
  localparam int unsigned BadBit   = FlagsLo + 3;

  typedef struct packed {
    logic               executed;
    logic [WordW-1:0]   value;
    logic [RegIdxW-1:0] rd;
    logic               wrote;
    flags_t             flags;
    logic               bad;
  } outcome_t;

  logic [WordW-1:0] shadow_regs [RegCnt];
  flags_t           shadow_flags;
  outcome_t         outcome_q [$];
  int unsigned      err_cnt;
  int unsigned      exec_cnt;
  int unsigned      bad_cnt;

  function automatic logic [WordW-1:0] ror32(logic [WordW-1:0] v, int unsigned n);
    n = n % 32;
    if (n == 0) return v;
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic cond_holds(logic [3:0] cc, flags_t f);
    case (cc)
      CondEq: return f.z;
      CondNe: return !f.z;
      CondCs: return f.c;
      CondCc: return !f.c;
      CondMi: return f.n;
      CondPl: return !f.n;
      CondVs: return 1'b0;
      CondVc: return 1'b1;
      CondHi: return f.c && !f.z;
      CondLs: return !f.c || f.z;
      CondGe: return !f.n;
      CondLt: return f.n;
      CondGt: return !f.z && !f.n;
      CondLe: return f.z || f.n;
      CondAl: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Operand 2 with the shifter carry-out on top
  function automatic logic [WordW:0] shifter_out(logic [WordW-1:0] w);
    logic [WordW-1:0] v;
    logic [WordW-1:0] r;
    logic [7:0]       amt;
    int unsigned      rot;
    logic             cin;
    cin = shadow_flags.c;
    if (w[25]) begin
      rot = 2 * w[11:8];
      v = ror32({24'd0, w[7:0]}, rot);
      return {(rot == 0) ? cin : v[31], v};
    end
    v = shadow_regs[w[3:0]];
    amt = w[4] ? shadow_regs[w[11:8]][7:0] : {3'd0, w[11:7]};
    if (amt == 0) return {cin, v};
    case (w[6:5])
      ShLsl: begin
        if (amt < 32) return {v[32 - amt], v << amt};
        return {(amt == 32) ? v[0] : 1'b0, 32'd0};
      end
      ShLsr: begin
        if (amt < 32) return {v[amt - 1], v >> amt};
        return {(amt == 32) ? v[31] : 1'b0, 32'd0};
      end
      ShAsr: begin
        if (amt < 32) return {v[amt - 1], WordW'($signed(v) >>> amt)};
        return {v[31], {WordW{v[31]}}};
      end
      default: begin
        r = ror32(v, amt);
        return {r[31], r};
      end
    endcase
  endfunction

  // Execute one instruction on the shadow state and queue its outcome
  task automatic execute_shadow(input logic [WordW-1:0] w);
    outcome_t         o;
    logic [WordW:0]   sh;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] res;
    logic             supported;
    logic             logical;
    logic             writes;
    logic             c;
    o = '0;
    o.rd = w[15:12];
    if (cond_holds(w[31:28], shadow_flags)) begin
      sh = shifter_out(w);
      b = sh[WordW-1:0];
      a = shadow_regs[w[19:16]];
      supported = 1'b1;
      logical = 1'b1;
      writes = 1'b1;
      c = 1'b0;
      res = '0;
      case (w[24:21])
        OpAnd: res = a & b;
        OpEor: res = a ^ b;
        OpSub: begin
          res = a - b; logical = 1'b0; c = (a >= b);
        end
        OpRsb: begin
          res = b - a; logical = 1'b0; c = (b >= a);
        end
        OpAdd: begin
          {c, res} = {1'b0, a} + {1'b0, b}; logical = 1'b0;
        end
        OpTst: begin
          res = a & b; writes = 1'b0;
        end
        OpTeq: begin
          res = a ^ b; writes = 1'b0;
        end
        OpCmp: begin
          res = a - b; logical = 1'b0; writes = 1'b0; c = (a >= b);
        end
        OpOrr: res = a | b;
        OpMov: res = b;
        default: supported = 1'b0;
      endcase
      if (supported) begin
        o.executed = 1'b1;
        o.value = res;
        exec_cnt++;
        if (writes) begin
          shadow_regs[w[15:12]] = res;
          o.wrote = 1'b1;
        end
        if (w[20]) begin
          if (logical) c = sh[WordW];
          shadow_flags = {res[31], res == 0, c};
        end
      end else begin
        o.bad = 1'b1;
        bad_cnt++;
      end
    end
    o.flags = shadow_flags;
    outcome_q.push_back(o);
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] want,
                             input logic [WordW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Compare result transfers first, then predict the instruction transfer
  always @(posedge clk) begin
    outcome_t o;
    if (rst) begin
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      shadow_flags = '0;
      outcome_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no instruction outstanding: %0h", m_tdata);
          err_cnt++;
        end else begin
          o = outcome_q.pop_front();
          check_field("executed", WordW'(o.executed), WordW'(m_tdata[ExecBit]));
          check_field("result_value", o.value, m_tdata[ValueLo +: WordW]);
          check_field("dest_index", WordW'(o.rd), WordW'(m_tdata[RdLo +: RegIdxW]));
          check_field("dest_written", WordW'(o.wrote), WordW'(m_tdata[WroteBit]));
          check_field("flags_nzc", WordW'(o.flags), WordW'(m_tdata[FlagsLo +: 3]));
          check_field("bad_opcode", WordW'(o.bad), WordW'(m_tdata[BadBit]));
        end
      end
      if (s_tvalid && s_tready) execute_shadow(s_tdata);
    end
    errors     <= err_cnt;
    pending    <= outcome_q.size();
    n_executed <= exec_cnt;
    n_bad      <= bad_cnt;
  end

endmodule

// File: dv/tb_top.sv
module tb_top;
  import dpeu_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ItemsPerPhase = 363;
  localparam int unsigned NumPhases     = 4;

  // Opcodes the block does not support
  localparam logic [3:0] OpUndef5  = 4'd5;
  localparam logic [3:0] OpUndef6  = 4'd6;
  localparam logic [3:0] OpUndef7  = 4'd7;
  localparam logic [3:0] OpUndef11 = 4'd11;
  localparam logic [3:0] OpUndef14 = 4'd14;
  localparam logic [3:0] OpUndef15 = 4'd15;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [WordW-1:0]    s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int unsigned errors;
  int unsigned pending;
  int unsigned n_executed;
  int unsigned n_bad;
  int unsigned sent_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  int unsigned phase_idle  [NumPhases] = '{0, 49, 0, 31};
  int unsigned phase_stall [NumPhases] = '{0, 0, 49, 31};
  logic [3:0]  dp_ops      [10] = '{OpAnd, OpEor, OpSub, OpRsb, OpAdd,
                                    OpTst, OpTeq, OpCmp, OpOrr, OpMov};
  logic [3:0]  undef_ops   [6]  = '{OpUndef5, OpUndef6, OpUndef7,
                                    OpUndef11, OpUndef14, OpUndef15};
  // Immediates that make useful shift amounts once loaded into a register
  logic [7:0]  amt_values  [12] = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd33, 8'd64,
                                    8'd96, 8'h80, 8'hA0, 8'hE0, 8'hFF, 8'h7F};

  data_processing_execute_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dpeu_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .errors     (errors),
    .pending    (pending),
    .n_executed (n_executed),
    .n_bad      (n_bad)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [WordW-1:0] dp_imm(logic [3:0] cc, logic [3:0] op, logic s,
                                              logic [3:0] rn, logic [3:0] rd,
                                              logic [3:0] rot, logic [7:0] imm8);
    return {cc, 2'b00, 1'b1, op, s, rn, rd, rot, imm8};
  endfunction

  // Register operand: shift by Rs when by_reg, else by the immediate amount
  function automatic logic [WordW-1:0] dp_reg(logic [3:0] cc, logic [3:0] op, logic s,
                                              logic [3:0] rn, logic [3:0] rd,
                                              logic [1:0] sh, logic by_reg,
                                              logic [4:0] amt, logic [3:0] rs,
                                              logic [3:0] rm);
    if (by_reg) return {cc, 2'b00, 1'b0, op, s, rn, rd, rs, 1'b0, sh, 1'b1, rm};
    return {cc, 3'b000, op, s, rn, rd, amt, sh, 1'b0, rm};
  endfunction

  // Mostly well-formed instructions, some loads of shift amounts, some noise
  function automatic logic [WordW-1:0] rand_instr();
    logic [WordW-1:0] w;
    int unsigned      pick;
    w = $urandom();
    pick = $urandom_range(99);
    if (pick < 8) return w;
    w[31:28] = ($urandom_range(9) < 7) ? CondAl : 4'($urandom_range(15));
    if (pick < 30) begin
      w[25] = 1'b1;
      w[24:21] = OpMov;
      if ($urandom_range(3) != 0) w[11:8] = '0;
      if ($urandom_range(3) != 0) w[7:0] = amt_values[$urandom_range(11)];
      return w;
    end
    w[24:21] = ($urandom_range(19) == 0) ? undef_ops[$urandom_range(5)]
                                         : dp_ops[$urandom_range(9)];
    if (!w[25] && !w[4] && $urandom_range(5) == 0) w[11:7] = '0;
    return w;
  endfunction

  // Offer one instruction after a random gap and hold it until the transfer
  task automatic send_instr(input logic [WordW-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    sent_cnt++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Load registers with shift amounts and rotated immediates
    send_instr(dp_imm(CondAl, OpMov, 1'b1, 4'd0, 4'd1, 4'd0, 8'hFF));
    send_instr(dp_imm(CondAl, OpMov, 1'b1, 4'd0, 4'd2, 4'd4, 8'hFF));
    send_instr(dp_imm(CondAl, OpMov, 1'b0, 4'd0, 4'd4, 4'd0, 8'd32));
    send_instr(dp_imm(CondAl, OpMov, 1'b0, 4'd0, 4'd5, 4'd0, 8'd33));
    send_instr(dp_imm(CondAl, OpMov, 1'b0, 4'd0, 4'd6, 4'd0, 8'd64));
    send_instr(dp_imm(CondAl, OpMov, 1'b0, 4'd0, 4'd7, 4'd0, 8'hA0));
    send_instr(dp_imm(CondAl, OpMov, 1'b0, 4'd0, 4'd8, 4'd0, 8'h81));
    // Register amounts of 32 and above, a multiple of 32 on ROR, bit 7 set
    send_instr(dp_reg(CondAl, OpMov, 1'b1, 4'd0, 4'd9, ShLsl, 1'b1, 5'd0, 4'd4, 4'd2));
    send_instr(dp_reg(CondAl, OpMov, 1'b1, 4'd0, 4'd10, ShLsr, 1'b1, 5'd0, 4'd4, 4'd2));
    send_instr(dp_reg(CondAl, OpMov, 1'b1, 4'd0, 4'd11, ShAsr, 1'b1, 5'd0, 4'd5, 4'd2));
    send_instr(dp_reg(CondAl, OpMov, 1'b1, 4'd0, 4'd12, ShRor, 1'b1, 5'd0, 4'd7, 4'd2));
    send_instr(dp_reg(CondAl, OpMov, 1'b1, 4'd0, 4'd13, ShLsl, 1'b1, 5'd0, 4'd5, 4'd1));
    send_instr(dp_reg(CondAl, OpMov, 1'b1, 4'd0, 4'd3, ShLsr, 1'b1, 5'd0, 4'd8, 4'd2));
    // Zero shift amounts keep the carry
    send_instr(dp_reg(CondAl, OpMov, 1'b1, 4'd0, 4'd3, ShAsr, 1'b0, 5'd0, 4'd0, 4'd2));
    send_instr(dp_reg(CondAl, OpMov, 1'b1, 4'd0, 4'd3, ShRor, 1'b1, 5'd0, 4'd0, 4'd1));
    // Every operation, with carry out and borrow
    send_instr(dp_reg(CondAl, OpAdd, 1'b1, 4'd2, 4'd14, ShLsl, 1'b0, 5'd0, 4'd0, 4'd2));
    send_instr(dp_reg(CondAl, OpSub, 1'b1, 4'd1, 4'd14, ShLsl, 1'b0, 5'd0, 4'd0, 4'd1));
    send_instr(dp_imm(CondAl, OpRsb, 1'b1, 4'd1, 4'd14, 4'd0, 8'h01));
    send_instr(dp_reg(CondAl, OpCmp, 1'b1, 4'd2, 4'd0, ShLsl, 1'b0, 5'd0, 4'd0, 4'd1));
    send_instr(dp_imm(CondAl, OpTst, 1'b1, 4'd2, 4'd0, 4'd4, 8'h80));
    send_instr(dp_reg(CondAl, OpTeq, 1'b1, 4'd1, 4'd0, ShLsl, 1'b0, 5'd0, 4'd0, 4'd1));
    send_instr(dp_reg(CondAl, OpEor, 1'b0, 4'd1, 4'd3, ShRor, 1'b0, 5'd4, 4'd0, 4'd2));
    send_instr(dp_reg(CondAl, OpOrr, 1'b1, 4'd1, 4'd3, ShLsr, 1'b0, 5'd31, 4'd0, 4'd2));
    send_instr(dp_reg(CondAl, OpAnd, 1'b1, 4'd2, 4'd3, ShAsr, 1'b0, 5'd1, 4'd0, 4'd2));
    // Unsupported opcode, never-condition, failed condition on a bad opcode
    send_instr(dp_imm(CondAl, OpUndef5, 1'b1, 4'd1, 4'd3, 4'd0, 8'h55));
    send_instr(dp_imm(CondNv, OpMov, 1'b1, 4'd0, 4'd3, 4'd0, 8'h12));
    send_instr(dp_imm(CondVs, OpUndef14, 1'b1, 4'd1, 4'd3, 4'd0, 8'h34));

    // Random instructions under each idle mix
    for (int p = 0; p < NumPhases; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (ItemsPerPhase) send_instr(rand_instr());
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("tb_top: %0d instructions, %0d executed, %0d bad opcode, %0d skipped on condition",
             sent_cnt, n_executed, n_bad, sent_cnt - n_executed - n_bad);
    $display("tb_top: sender/receiver idle mixes 0/0, 49/0, 0/49, 31/31 percent");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
